FILE: design/stbs_pkg.sv
// ---------------------------------------------------------------------------
// Sorted table binary search package
// Shared sizes, item kind codes, controller states and the result record.
// ---------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int POS_W     = CNT_W + 1;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int MATCH_W   = 10;
    localparam int M_TDATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_OUT
    } state_t;

    // The found flag sits in the lowest bit so the record maps onto tdata directly.
    typedef struct packed {
        logic [MATCH_W-1:0] match_index;
        logic               found;
    } result_t;

endpackage

FILE: design/stbs_ram.sv
// ---------------------------------------------------------------------------
// Table memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module stbs_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/stbs_ctrl.sv
// ---------------------------------------------------------------------------
// Search controller
// Decodes input items, keeps the entry count and walks the binary search
// through the table memory, each probe an ST_ADDR then an ST_CMP state.
// ---------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [stbs_pkg::KIND_W-1:0]       in_kind,
    input  logic signed [stbs_pkg::DATA_W-1:0] in_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output stbs_pkg::result_t                 res,
    output logic                              ram_we,
    output logic [stbs_pkg::ADDR_W-1:0]       ram_waddr,
    output logic [stbs_pkg::DATA_W-1:0]       ram_wdata,
    output logic                              ram_re,
    output logic [stbs_pkg::ADDR_W-1:0]       ram_raddr,
    input  logic [stbs_pkg::DATA_W-1:0]       ram_rdata
);

    localparam logic signed [stbs_pkg::POS_W-1:0] ONE_POS = stbs_pkg::POS_W'(1);
    localparam logic [stbs_pkg::CNT_W-1:0] FULL_CNT = stbs_pkg::CNT_W'(stbs_pkg::DEPTH);

    stbs_pkg::state_t state_reg, state_next;

    logic [stbs_pkg::CNT_W-1:0]         count_reg, count_next;
    logic signed [stbs_pkg::DATA_W-1:0] target_reg, target_next;
    logic signed [stbs_pkg::POS_W-1:0]  left_reg, left_next;
    logic signed [stbs_pkg::POS_W-1:0]  right_reg, right_next;
    logic [stbs_pkg::ADDR_W-1:0]        mid_reg, mid_next;
    stbs_pkg::result_t                  res_reg, res_next;

    logic                               accept;
    logic                               is_search;
    logic                               is_append;
    logic                               is_clear;
    logic                               exhausted;
    logic signed [stbs_pkg::POS_W-1:0]  span;
    logic signed [stbs_pkg::POS_W-1:0]  mid_pos;
    logic signed [stbs_pkg::POS_W-1:0]  mid_ext;
    logic signed [stbs_pkg::DATA_W-1:0] probe;

    assign accept = in_valid && in_ready;

    always_comb begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_search = 1'b0;
        unique case (in_kind)
            stbs_pkg::KIND_CLEAR:  is_clear  = 1'b1;
            stbs_pkg::KIND_APPEND: is_append = 1'b1;
            stbs_pkg::KIND_SEARCH: is_search = 1'b1;
            default: ;
        endcase
    end

    // The interval is never empty when the midpoint is used, so the span is not negative.
    assign exhausted = left_reg > right_reg;
    assign span      = right_reg - left_reg;
    assign mid_pos   = left_reg + (span >>> 1);
    assign mid_ext   = $signed({2'b00, mid_reg});
    assign probe     = $signed(ram_rdata);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stbs_pkg::ST_IDLE: begin
                if (accept && is_search) state_next = stbs_pkg::ST_ADDR;
            end
            stbs_pkg::ST_ADDR: begin
                state_next = exhausted ? stbs_pkg::ST_OUT : stbs_pkg::ST_CMP;
            end
            stbs_pkg::ST_CMP: begin
                state_next = (probe == target_reg) ? stbs_pkg::ST_OUT : stbs_pkg::ST_ADDR;
            end
            stbs_pkg::ST_OUT: begin
                if (res_ready) state_next = stbs_pkg::ST_IDLE;
            end
            default: state_next = stbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == stbs_pkg::ST_IDLE);
        res_valid = (state_reg == stbs_pkg::ST_OUT);
        res       = res_reg;
        ram_we    = accept && is_append && (count_reg < FULL_CNT);
        ram_waddr = count_reg[stbs_pkg::ADDR_W-1:0];
        ram_wdata = in_value;
        ram_re    = (state_reg == stbs_pkg::ST_ADDR) && !exhausted;
        ram_raddr = mid_pos[stbs_pkg::ADDR_W-1:0];
    end

    always_comb begin
        count_next  = count_reg;
        target_next = target_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        mid_next    = mid_reg;
        res_next    = res_reg;
        case (state_reg)
            stbs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_clear) count_next = '0;
                    if (ram_we)   count_next = count_reg + stbs_pkg::CNT_W'(1);
                    if (is_search) begin
                        target_next = in_value;
                        left_next   = '0;
                        right_next  = $signed({1'b0, count_reg}) - ONE_POS;
                    end
                end
            end
            stbs_pkg::ST_ADDR: begin
                mid_next = mid_pos[stbs_pkg::ADDR_W-1:0];
                if (exhausted) begin
                    res_next.found       = 1'b0;
                    res_next.match_index = '0;
                end
            end
            stbs_pkg::ST_CMP: begin
                if (probe == target_reg) begin
                    res_next.found       = 1'b1;
                    res_next.match_index = stbs_pkg::MATCH_W'(mid_reg);
                end else if (probe > target_reg) begin
                    right_next = mid_ext - ONE_POS;
                end else begin
                    left_next = mid_ext + ONE_POS;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stbs_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg <= target_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        mid_reg    <= mid_next;
        res_reg    <= res_next;
    end

endmodule

FILE: design/sorted_table_binary_search_top.sv
// ---------------------------------------------------------------------------
// Sorted table binary search, top level
// Holds a table of signed values loaded in ascending order and answers
// binary search queries over the loaded entries.
// ---------------------------------------------------------------------------
// Input channel (s_*): one item per handshake. s_tuser carries the kind
// (clear, append, search) and s_tdata the value to append or the target.
// Clear and append finish in the cycle they are accepted and give no result;
// the next item is taken in the following cycle.
// Result channel (m_*): one item per search, found flag in bit 0 and the
// index of the first probed match in bits 10:1 (zero when not found).
// A search makes at most floor(log2(n))+1 probes over n loaded entries. Each
// probe addresses the table memory in ST_ADDR and compares its registered
// read data in ST_CMP. A hit, or an interval left empty in ST_ADDR, ends the
// search in ST_OUT, from which the result moves into the output register;
// the controller then returns to idle and takes the next item.
// The output register lets a new item be accepted while a result waits; if
// the receiver stalls, a second search holds in its last cycle until the
// register frees up. Reset empties the table (entry count zero) and clears
// all valid flags; table contents are left as they are.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stbs_pkg::DATA_W-1:0]        s_tdata,  // [31:0] search_value
    input  logic [stbs_pkg::KIND_W-1:0]        s_tuser,  // [1:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]     m_tdata   // [0] found, [10:1] match_index
);

    logic                          res_valid;
    logic                          res_ready;
    stbs_pkg::result_t             res;
    logic                          ram_we;
    logic [stbs_pkg::ADDR_W-1:0]   ram_waddr;
    logic [stbs_pkg::DATA_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [stbs_pkg::ADDR_W-1:0]   ram_raddr;
    logic [stbs_pkg::DATA_W-1:0]   ram_rdata;

    logic                          m_valid_reg, m_valid_next;
    stbs_pkg::result_t             m_data_reg, m_data_next;

    stbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_value  ($signed(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    stbs_ram #(
        .DATA_W (stbs_pkg::DATA_W),
        .ADDR_W (stbs_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) m_data_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = stbs_pkg::M_TDATA_W'(m_data_reg);

endmodule

FILE: design/stbs_checker.sv
// ---------------------------------------------------------------------------
// Search block checker
// Port-level assertions on the top level, attached by a bind statement.
// ---------------------------------------------------------------------------
module stbs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [stbs_pkg::DATA_W-1:0]    s_tdata,
    input logic [stbs_pkg::KIND_W-1:0]    s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [stbs_pkg::M_TDATA_W-1:0] m_tdata
);

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A miss always reports index zero, and the padding stays clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || m_tdata[10:1] == 10'd0) && m_tdata[15:11] == 5'd0)
        else $error("malformed result item");

    // A search occupies the block for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == stbs_pkg::KIND_SEARCH |=> !s_tready)
        else $error("input taken during a search");

    // Clear, append and unused kinds produce no result item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_accept && s_tuser != stbs_pkg::KIND_SEARCH |=> !m_tvalid)
        else $error("result without a search");

    // No accepted item, search or otherwise, delivers a result in the cycle after acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_accept |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
